### hdl/tsg_pkg.sv
// Shared types, widths and helpers for the top sector grouping block.
// No dependencies; imported by top_sector_grouping.

package tsg_pkg;

    localparam int TSG_MASK_W        = 16;
    localparam int TSG_POS_W         = 5;
    localparam int TSG_CFG_W         = 5;
    localparam int TSG_MAX_INDICES   = 16;
    localparam int TSG_MAX_INTEGRALS = 32;
    localparam int TSG_INDEX_WIDTH   = 8;

    localparam logic [TSG_CFG_W-1:0] TSG_NUM_INDICES_RST = TSG_CFG_W'(16);

    // position, group, sector mask and overflow flag, packed from bit 0 up
    localparam int TSG_OUT_USED_W = 2 * TSG_POS_W + TSG_MASK_W + 1;
    localparam int TSG_OUT_DATA_W = ((TSG_OUT_USED_W + 7) / 8) * 8;

    typedef enum logic {
        KIND_TOP      = 1'b0,
        KIND_INTEGRAL = 1'b1
    } kind_t;

    typedef enum logic [15:0] {
        ST_LOAD     = 16'h0001,
        ST_D_WAIT_I = 16'h0002,
        ST_D_CUR    = 16'h0004,
        ST_D_WAIT_J = 16'h0008,
        ST_D_CMP    = 16'h0010,
        ST_D_APPEND = 16'h0020,
        ST_T_WAIT_I = 16'h0040,
        ST_T_CUR    = 16'h0080,
        ST_T_WAIT_J = 16'h0100,
        ST_T_CMP    = 16'h0200,
        ST_T_EMIT   = 16'h0400,
        ST_A_WAIT_I = 16'h0800,
        ST_A_CUR    = 16'h1000,
        ST_A_WAIT_J = 16'h2000,
        ST_A_CMP    = 16'h4000,
        ST_A_EMIT   = 16'h8000
    } state_t;

    // True when every bit of a is also set in b.
    function automatic logic contained(input logic [TSG_MASK_W-1:0] a,
                                       input logic [TSG_MASK_W-1:0] b);
        contained = ((a & ~b) == '0);
    endfunction

endpackage

### hdl/top_sector_grouping.sv
// Top sector grouping: loads integral masks, then finds distinct and top sectors.
// Depends on tsg_pkg for widths, state and record kind types.
//
// Channel   Direction  Handshake               Payload
// s_axis    in         s_axis_tvalid/tready    tdata: index_value; tlast: end_of_list
// m_axis    out        m_axis_tvalid/tready    tdata: position, group, mask, overflow;
//                                              tuser: record_kind; tlast: last
// cfg       in         cfg_valid/cfg_ready     cfg_data: num_indices
//
// An item that does not end the list is taken while loading. The item that ends it
// starts grouping, during which the input is not ready: deduplication, then the top
// sector search, then assignment, each reading the distinct store through its single
// read port, with output stalls able to hold it. Reset is synchronous and active low.

module top_sector_grouping
    import tsg_pkg::*;
#(
    parameter int MAX_INDICES   = TSG_MAX_INDICES,
    parameter int MAX_INTEGRALS = TSG_MAX_INTEGRALS,
    parameter int INDEX_WIDTH   = TSG_INDEX_WIDTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // [INDEX_WIDTH-1:0] index_value (signed), rest zero
    input  logic [((INDEX_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  logic                      s_axis_tlast,

    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [4:0] position, [9:5] group, [25:10] sector_mask, [26] overflow, rest zero
    output logic [TSG_OUT_DATA_W-1:0] m_axis_tdata,
    // [0] record_kind
    output logic                      m_axis_tuser,
    output logic                      m_axis_tlast,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [TSG_CFG_W-1:0]      cfg_data
);

    localparam int AW  = (MAX_INTEGRALS > 1) ? $clog2(MAX_INTEGRALS) : 1;
    localparam int CW  = $clog2(MAX_INTEGRALS + 1);
    localparam int ICW = $clog2(MAX_INDICES + 1);

    state_t                    state_reg, state_next;
    logic [TSG_CFG_W-1:0]      num_indices_reg;
    logic [ICW-1:0]            idx_reg, idx_next;
    logic [TSG_MASK_W-1:0]     mask_reg, mask_next;
    logic [CW-1:0]             icnt_reg, icnt_next;
    logic [CW-1:0]             dcnt_reg, dcnt_next;
    logic                      ovf_reg, ovf_next;
    logic [MAX_INTEGRALS-1:0]  top_flags_reg, top_flags_next;
    logic [CW-1:0]             i_reg, i_next;
    logic [CW-1:0]             j_reg, j_next;
    logic [CW-1:0]             tcnt_reg, tcnt_next;
    logic [CW-1:0]             grp_reg, grp_next;
    logic                      top_reg, top_next;
    logic [TSG_MASK_W-1:0]     cur_reg, cur_next;

    logic [TSG_MASK_W-1:0]     imem [MAX_INTEGRALS];
    logic [TSG_MASK_W-1:0]     dmem [MAX_INTEGRALS];
    logic [TSG_MASK_W-1:0]     i_rdata_reg, d_rdata_reg;
    logic [AW-1:0]             d_raddr;
    logic                      i_we, d_we;

    logic                      m_valid_reg;
    kind_t                     out_kind_reg;
    logic [TSG_POS_W-1:0]      out_pos_reg, out_grp_reg;
    logic [TSG_MASK_W-1:0]     out_mask_reg;
    logic                      out_ovf_reg, out_last_reg;

    logic                      ld_out, ld_last;
    kind_t                     ld_kind;
    logic [CW-1:0]             ld_pos, ld_grp;
    logic                      out_free;

    logic signed [INDEX_WIDTH-1:0] index_value;
    logic [ICW-1:0]            n_eff, idx_inc;
    logic [TSG_MASK_W-1:0]     mask_new;
    logic                      store_now, d_adv, t_adv, top_now, hit;
    logic [CW-1:0]             i_inc, j_inc;

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign cfg_ready     = 1'b1;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign index_value = s_axis_tdata[INDEX_WIDTH-1:0];
    assign idx_inc     = idx_reg + ICW'(1);
    assign i_inc       = i_reg + CW'(1);
    assign j_inc       = j_reg + CW'(1);

    // A shift past the mask width yields zero, so late indices set no bit.
    assign mask_new  = mask_reg
                     | ((TSG_MASK_W'(1) << idx_reg) & {TSG_MASK_W{index_value > 0}});
    assign store_now = (idx_inc >= n_eff) || s_axis_tlast;

    always_comb begin
        if (num_indices_reg == '0) begin
            n_eff = ICW'(1);
        end else if (int'(num_indices_reg) > MAX_INDICES) begin
            n_eff = ICW'(MAX_INDICES);
        end else begin
            n_eff = ICW'(num_indices_reg);
        end
    end

    // The top sector search reads its outer mask from the distinct store too.
    assign d_raddr = (state_reg == ST_T_WAIT_I) ? i_reg[AW-1:0] : j_reg[AW-1:0];

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        mask_next      = mask_reg;
        icnt_next      = icnt_reg;
        dcnt_next      = dcnt_reg;
        ovf_next       = ovf_reg;
        top_flags_next = top_flags_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        tcnt_next      = tcnt_reg;
        grp_next       = grp_reg;
        top_next       = top_reg;
        cur_next       = cur_reg;
        i_we           = 1'b0;
        d_we           = 1'b0;
        d_adv          = 1'b0;
        t_adv          = 1'b0;
        ld_out         = 1'b0;
        ld_kind        = KIND_TOP;
        ld_pos         = '0;
        ld_grp         = '0;
        ld_last        = 1'b0;
        top_now        = top_reg;
        hit            = contained(cur_reg, d_rdata_reg);

        case (state_reg)
            ST_LOAD: begin
                if (s_axis_tvalid) begin
                    if (store_now) begin
                        idx_next  = '0;
                        mask_next = '0;
                        if (icnt_reg < CW'(MAX_INTEGRALS)) begin
                            i_we      = 1'b1;
                            icnt_next = icnt_reg + CW'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end else begin
                        idx_next  = idx_inc;
                        mask_next = mask_new;
                    end
                    if (s_axis_tlast) begin
                        i_next     = '0;
                        dcnt_next  = '0;
                        state_next = ST_D_WAIT_I;
                    end
                end
            end
            ST_D_WAIT_I: begin
                state_next = ST_D_CUR;
            end
            ST_D_CUR: begin
                cur_next   = i_rdata_reg;
                j_next     = '0;
                state_next = (dcnt_reg == '0) ? ST_D_APPEND : ST_D_WAIT_J;
            end
            ST_D_WAIT_J: begin
                state_next = ST_D_CMP;
            end
            ST_D_CMP: begin
                if (d_rdata_reg == cur_reg) begin
                    d_adv = 1'b1;
                end else if (j_inc == dcnt_reg) begin
                    state_next = ST_D_APPEND;
                end else begin
                    j_next     = j_inc;
                    state_next = ST_D_WAIT_J;
                end
            end
            ST_D_APPEND: begin
                d_we      = 1'b1;
                dcnt_next = dcnt_reg + CW'(1);
                d_adv     = 1'b1;
            end
            ST_T_WAIT_I: begin
                state_next = ST_T_CUR;
            end
            ST_T_CUR: begin
                cur_next   = d_rdata_reg;
                j_next     = '0;
                top_next   = 1'b1;
                state_next = ST_T_WAIT_J;
            end
            ST_T_WAIT_J: begin
                state_next = ST_T_CMP;
            end
            ST_T_CMP: begin
                // Distinct masks differ, so containment in another one is strict.
                top_now  = top_reg && !((j_reg != i_reg) && hit);
                top_next = top_now;
                if (j_inc == dcnt_reg) begin
                    top_flags_next[i_reg[AW-1:0]] = top_now;
                    if (top_now) begin
                        state_next = ST_T_EMIT;
                    end else begin
                        t_adv = 1'b1;
                    end
                end else begin
                    j_next     = j_inc;
                    state_next = ST_T_WAIT_J;
                end
            end
            ST_T_EMIT: begin
                if (out_free) begin
                    ld_out    = 1'b1;
                    ld_kind   = KIND_TOP;
                    ld_pos    = tcnt_reg;
                    ld_grp    = tcnt_reg;
                    tcnt_next = tcnt_reg + CW'(1);
                    t_adv     = 1'b1;
                end
            end
            ST_A_WAIT_I: begin
                state_next = ST_A_CUR;
            end
            ST_A_CUR: begin
                cur_next   = i_rdata_reg;
                j_next     = '0;
                tcnt_next  = '0;
                grp_next   = '0;
                state_next = ST_A_WAIT_J;
            end
            ST_A_WAIT_J: begin
                state_next = ST_A_CMP;
            end
            ST_A_CMP: begin
                // tcnt counts the top sectors passed so far, giving each its ordinal.
                if (top_flags_reg[j_reg[AW-1:0]] && hit) begin
                    grp_next   = tcnt_reg;
                    state_next = ST_A_EMIT;
                end else begin
                    if (top_flags_reg[j_reg[AW-1:0]]) begin
                        tcnt_next = tcnt_reg + CW'(1);
                    end
                    if (j_inc == dcnt_reg) begin
                        state_next = ST_A_EMIT;
                    end else begin
                        j_next     = j_inc;
                        state_next = ST_A_WAIT_J;
                    end
                end
            end
            ST_A_EMIT: begin
                if (out_free) begin
                    ld_out  = 1'b1;
                    ld_kind = KIND_INTEGRAL;
                    ld_pos  = i_reg;
                    ld_grp  = grp_reg;
                    ld_last = (i_inc == icnt_reg);
                    if (i_inc == icnt_reg) begin
                        icnt_next      = '0;
                        dcnt_next      = '0;
                        top_flags_next = '0;
                        ovf_next       = 1'b0;
                        idx_next       = '0;
                        mask_next      = '0;
                        state_next     = ST_LOAD;
                    end else begin
                        i_next     = i_inc;
                        state_next = ST_A_WAIT_I;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase

        if (d_adv) begin
            if (i_inc == icnt_reg) begin
                i_next     = '0;
                tcnt_next  = '0;
                state_next = ST_T_WAIT_I;
            end else begin
                i_next     = i_inc;
                state_next = ST_D_WAIT_I;
            end
        end
        if (t_adv) begin
            if (i_inc == dcnt_reg) begin
                i_next     = '0;
                state_next = ST_A_WAIT_I;
            end else begin
                i_next     = i_inc;
                state_next = ST_T_WAIT_I;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_LOAD;
            num_indices_reg <= TSG_NUM_INDICES_RST;
            idx_reg         <= '0;
            mask_reg        <= '0;
            icnt_reg        <= '0;
            dcnt_reg        <= '0;
            ovf_reg         <= 1'b0;
            top_flags_reg   <= '0;
            i_reg           <= '0;
            j_reg           <= '0;
            tcnt_reg        <= '0;
            top_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            mask_reg      <= mask_next;
            icnt_reg      <= icnt_next;
            dcnt_reg      <= dcnt_next;
            ovf_reg       <= ovf_next;
            top_flags_reg <= top_flags_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            tcnt_reg      <= tcnt_next;
            top_reg       <= top_next;
            if (cfg_valid) begin
                num_indices_reg <= cfg_data;
            end
            if (ld_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        grp_reg <= grp_next;
        if (ld_out) begin
            out_kind_reg <= ld_kind;
            out_pos_reg  <= TSG_POS_W'(ld_pos);
            out_grp_reg  <= TSG_POS_W'(ld_grp);
            out_mask_reg <= cur_reg;
            out_ovf_reg  <= ovf_reg;
            out_last_reg <= ld_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (i_we) begin
            imem[icnt_reg[AW-1:0]] <= mask_new;
        end
        i_rdata_reg <= imem[i_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (d_we) begin
            dmem[dcnt_reg[AW-1:0]] <= cur_reg;
        end
        d_rdata_reg <= dmem[d_raddr];
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {(TSG_OUT_DATA_W - TSG_OUT_USED_W)'(0), out_ovf_reg,
                            out_mask_reg, out_grp_reg, out_pos_reg};

    a_dcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        dcnt_reg <= icnt_reg)
        else $error("distinct count exceeds stored integral count");

    a_flags_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> (top_flags_reg == '0))
        else $error("top flags left set while loading");

    a_group_has_integrals: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_LOAD) |-> (icnt_reg != '0) && (dcnt_reg <= icnt_reg))
        else $error("grouping started with no stored integral");

    a_last_is_integral: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == KIND_INTEGRAL))
        else $error("final item of a run is not an integral record");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for top_sector_grouping: random lists of integrals
// with random handshake gaps, checked record by record against a scoreboard.
// Depends on tsg_pkg and the top_sector_grouping RTL only.

module tb
    import tsg_pkg::*;
();

    localparam int IDLE_LIMIT   = 20000;
    localparam int RANDOM_ITEMS = 420;

    typedef struct packed {
        kind_t                 kind;
        logic [TSG_POS_W-1:0]  position;
        logic [TSG_POS_W-1:0]  group;
        logic [TSG_MASK_W-1:0] mask;
        logic                  overflow;
        logic                  last;
    } sector_record_t;

    // Tracks the load state of the block and the records each list should give.
    class grouping_scoreboard;
        logic [TSG_CFG_W-1:0]  num_indices;
        logic [TSG_MASK_W-1:0] integral_mask [TSG_MAX_INTEGRALS];
        int                    index_count;
        int                    integral_count;
        logic [TSG_MASK_W-1:0] mask_acc;
        bit                    dropped;
        sector_record_t        awaited [$];
        int                    errors;
        int                    records;
        int                    lists;
        int                    dropped_lists;

        function new();
            num_indices   = TSG_NUM_INDICES_RST;
            errors        = 0;
            records       = 0;
            lists         = 0;
            dropped_lists = 0;
            clear_list();
        endfunction

        function void clear_list();
            index_count    = 0;
            integral_count = 0;
            mask_acc       = '0;
            dropped        = 1'b0;
        endfunction

        function int span();
            if (num_indices == 0) return 1;
            if (num_indices > TSG_MAX_INDICES) return TSG_MAX_INDICES;
            return int'(num_indices);
        endfunction

        function void note_config(logic [TSG_CFG_W-1:0] value);
            num_indices = value;
        endfunction

        function void close_integral();
            if (integral_count < TSG_MAX_INTEGRALS) begin
                integral_mask[integral_count] = mask_acc;
                integral_count++;
            end else begin
                dropped = 1'b1;
            end
            index_count = 0;
            mask_acc    = '0;
        endfunction

        function void note_item(logic signed [TSG_INDEX_WIDTH-1:0] value, bit eol);
            if (index_count < TSG_MASK_W && value > 0) mask_acc[index_count] = 1'b1;
            index_count++;
            if (index_count >= span()) close_integral();
            if (eol) begin
                // A partial integral is stored with its missing indices left clear.
                if (index_count != 0) close_integral();
                predict_records();
                clear_list();
            end
        endfunction

        function void predict_records();
            logic [TSG_MASK_W-1:0] distinct [TSG_MAX_INTEGRALS];
            bit                    is_top [TSG_MAX_INTEGRALS];
            int                    ordinal [TSG_MAX_INTEGRALS];
            int                    n_distinct;
            int                    n_top;
            int                    g;
            bit                    seen;
            bit                    found;
            sector_record_t        rec;
            n_distinct = 0;
            for (int i = 0; i < integral_count; i++) begin
                seen = 1'b0;
                for (int j = 0; j < n_distinct; j++)
                    if (distinct[j] == integral_mask[i]) seen = 1'b1;
                if (!seen) begin
                    distinct[n_distinct] = integral_mask[i];
                    n_distinct++;
                end
            end
            n_top = 0;
            for (int i = 0; i < n_distinct; i++) begin
                is_top[i] = 1'b1;
                for (int j = 0; j < n_distinct; j++)
                    if (j != i && (distinct[i] & ~distinct[j]) == '0) is_top[i] = 1'b0;
                ordinal[i] = n_top;
                if (is_top[i]) begin
                    rec.kind     = KIND_TOP;
                    rec.position = TSG_POS_W'(n_top);
                    rec.group    = TSG_POS_W'(n_top);
                    rec.mask     = distinct[i];
                    rec.overflow = dropped;
                    rec.last     = 1'b0;
                    awaited.insert(awaited.size(), rec);
                    n_top++;
                end
            end
            // Every list stores at least one integral, so its last record is an
            // integral record.
            for (int i = 0; i < integral_count; i++) begin
                g     = 0;
                found = 1'b0;
                for (int j = 0; j < n_distinct; j++)
                    if (!found && is_top[j] && (integral_mask[i] & ~distinct[j]) == '0) begin
                        g     = ordinal[j];
                        found = 1'b1;
                    end
                rec.kind     = KIND_INTEGRAL;
                rec.position = TSG_POS_W'(i);
                rec.group    = TSG_POS_W'(g);
                rec.mask     = integral_mask[i];
                rec.overflow = dropped;
                rec.last     = (i == integral_count - 1);
                awaited.insert(awaited.size(), rec);
            end
            lists++;
            if (dropped) dropped_lists++;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_record(kind_t kind, logic [TSG_OUT_DATA_W-1:0] data, logic last);
            sector_record_t want;
            records++;
            if (awaited.size() == 0) begin
                $error("record arrived with none expected: kind %0d, data %h", kind, data);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare_field("record_kind", 32'(want.kind), 32'(kind));
            compare_field("position", 32'(want.position), 32'(data[TSG_POS_W-1:0]));
            compare_field("group", 32'(want.group),
                          32'(data[2*TSG_POS_W-1:TSG_POS_W]));
            compare_field("sector_mask", 32'(want.mask),
                          32'(data[2*TSG_POS_W+TSG_MASK_W-1 -: TSG_MASK_W]));
            compare_field("overflow", 32'(want.overflow),
                          32'(data[2*TSG_POS_W+TSG_MASK_W]));
            compare_field("last", 32'(want.last), 32'(last));
        endfunction
    endclass

    logic                       aclk          = 1'b0;
    logic                       aresetn       = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [TSG_INDEX_WIDTH-1:0] s_axis_tdata  = '0;
    logic                       s_axis_tlast  = 1'b0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [TSG_OUT_DATA_W-1:0]  m_axis_tdata;
    logic                       m_axis_tuser;
    logic                       m_axis_tlast;
    logic                       cfg_valid     = 1'b0;
    logic                       cfg_ready;
    logic [TSG_CFG_W-1:0]       cfg_data      = '0;

    grouping_scoreboard sb;
    bit                 sender_steady = 1'b0;
    bit                 sink_steady   = 1'b0;
    int                 sink_wait     = 0;
    int                 idle_cycles   = 0;
    int                 items_sent    = 0;

    top_sector_grouping uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Result side: checks each accepted item, then draws a stall for the next one.
    always @(posedge aclk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            sb.check_record(kind_t'(m_axis_tuser), m_axis_tdata, m_axis_tlast);
            if (sb.records % 40 == 0) sink_steady = ($urandom_range(0, 2) == 0);
            sink_wait = sink_steady ? 0 : $urandom_range(0, 9);
        end
        if (sink_wait > 0) begin
            sink_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timed out after %0d cycles without a transfer", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Valid stays high between back-to-back items; it is lowered only for a gap or a drain.
    task automatic send_item(logic [TSG_INDEX_WIDTH-1:0] value, bit eol);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= eol;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_item(value, eol);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_config(logic [TSG_CFG_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.note_config(value);
        cfg_valid <= 1'b0;
    endtask

    // Builds a list whose masks repeat and nest, unless it is shapeless, so that
    // deduplication and the containment search both have work to do.
    task automatic send_list(int integrals, bit cut_short, bit shapeless);
        int                         span;
        int                         cut;
        logic [TSG_MASK_W-1:0]      width_mask;
        logic [TSG_MASK_W-1:0]      pick;
        logic [TSG_MASK_W-1:0]      prior;
        logic [TSG_MASK_W-1:0]      made [$];
        logic [TSG_INDEX_WIDTH-1:0] value;
        bit                         eol;
        span       = sb.span();
        width_mask = (span >= TSG_MASK_W) ? '1 : TSG_MASK_W'((1 << span) - 1);
        cut        = (cut_short && span > 1) ? $urandom_range(1, span - 1) : span;
        for (int i = 0; i < integrals; i++) begin
            prior = (made.size() == 0) ? '0 : made[$urandom_range(0, made.size() - 1)];
            case ($urandom_range(0, 9))
                0, 1, 2, 3: pick = TSG_MASK_W'($urandom_range(0, 1) ? $urandom()
                                                                 : $urandom() & $urandom());
                4, 5:       pick = prior;
                default:    pick = prior & TSG_MASK_W'($urandom());
            endcase
            if (made.size() == 0) pick = TSG_MASK_W'($urandom());
            pick = pick & width_mask;
            made.insert(made.size(), pick);
            for (int k = 0; k < span; k++) begin
                if (shapeless)
                    value = TSG_INDEX_WIDTH'($urandom_range(0, 255));
                else if (pick[k])
                    value = TSG_INDEX_WIDTH'($urandom_range(1, 127));
                else if ($urandom_range(0, 2) == 0)
                    value = '0;
                else
                    value = TSG_INDEX_WIDTH'($urandom_range(128, 255));
                eol = (i == integrals - 1) && (k == cut - 1);
                send_item(value, eol);
                items_sent++;
                if (eol) break;
            end
        end
    endtask

    initial begin
        int integrals;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset setting of sixteen indices; the list ends inside its first integral.
        sender_steady = 1'b1;
        send_item(8'h7F, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'hFF, 1'b1);
        // Zero acts as one index per integral: repeated masks and a contained empty one.
        write_config(5'd0);
        send_item(8'h05, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFD, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'h02, 1'b1);
        // The largest setting is clamped to sixteen: one full integral, every bit set.
        sender_steady = 1'b0;
        write_config(5'd31);
        for (int k = 0; k < TSG_MAX_INDICES; k++)
            send_item(TSG_INDEX_WIDTH'(k + 1), k == TSG_MAX_INDICES - 1);

        // More integrals than the store holds.
        items_sent = 0;
        write_config(5'd1);
        send_list(36, 1'b0, 1'b0);

        while (items_sent < RANDOM_ITEMS) begin
            sender_steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 5))
                0, 1: begin
                    case ($urandom_range(0, 7))
                        0:       write_config(5'd0);
                        1:       write_config(5'd31);
                        2:       write_config(5'd16);
                        3:       write_config(TSG_CFG_W'($urandom_range(17, 30)));
                        default: write_config(TSG_CFG_W'($urandom_range(1, 6)));
                    endcase
                end
                2:       drain_results();
                default: ;
            endcase
            if ($urandom_range(0, 7) == 0 && sb.span() <= 4)
                integrals = $urandom_range(30, 40);
            else
                integrals = $urandom_range(1, 8);
            send_list(integrals, $urandom_range(0, 4) == 0, $urandom_range(0, 7) == 0);
        end

        drain_results();
        repeat (40) @(posedge aclk);
        $display("Ran %0d lists giving %0d records; %0d of the lists overflowed the store.",
                 sb.lists, sb.records, sb.dropped_lists);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
